// ----- rtl/sgp_pkg.sv -----
`timescale 1ns / 1ps
package sgp_pkg;
  localparam int MaxVerts = 65536;
  localparam int MaxParts = 16;
  localparam int VW = $clog2(MaxVerts);
  localparam int PW = $clog2(MaxParts);
  localparam int CW = 17;
  localparam int TW = 16;
  localparam logic [CW-1:0] CntMax = {CW{1'b1}};

  localparam logic [1:0] ReqNbr = 2'd0;
  localparam logic [1:0] ReqRand = 2'd1;
  localparam logic [1:0] ReqTable = 2'd2;

  localparam logic [1:0] AddrNumParts = 2'd0;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_NBR_RD, ST_NBR_UPD, ST_TBL_RD, ST_TBL_WAIT, ST_SCORE,
    ST_MEM_RD, ST_MEM_WAIT, ST_PLACE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic nbr_rd;
    logic nbr_upd;
    logic tbl_wr;
    logic tbl_rd;
    logic score;
    logic mem_rd;
    logic place;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_nbr;
    logic is_rand;
    logic is_table;
    logic last;
    logic scan_done;
  } stat_t;
endpackage

// ----- rtl/streaming_graph_partitioner.sv -----
`timescale 1ns / 1ps
// channel | signals                                   | handshake
// input   | req_type vertex neighbor last_neighbor ... | start & !busy
// result  | placed_vertex chosen_part had_old_part ... | done, one cycle
// config  | psel penable pwrite paddr pwdata prdata    | APB, pready high
// Steps: a table write in the neighbor read state; a neighbor item reads
// membership then updates counts; a marked item then scores each partition
// (table read, wait, score) before membership read, wait and place, as does a
// vertex without neighbors. After reset a clearing pass sweeps the 65536
// membership entries; busy holds until it ends.
// The result receiver cannot stall.
module streaming_graph_partitioner import sgp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [15:0] vertex,
  input  logic [15:0] neighbor,
  input  logic        last_neighbor,
  input  logic [3:0]  random_part,
  input  logic [15:0] table_index,
  input  logic [23:0] table_value,
  output logic        done,
  output logic [15:0] placed_vertex,
  output logic [3:0]  chosen_part,
  output logic        had_old_part,
  output logic [3:0]  old_part,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cmd_t cmd;
  stat_t st;
  logic [4:0] num_parts;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) num_parts <= 5'd16;
    else if (psel && penable && pwrite && paddr == AddrNumParts) num_parts <= pwdata[4:0];
  end
  assign prdata = (paddr == AddrNumParts) ? {27'b0, num_parts} : 32'b0;

  sgp_ctrl u_ctrl (.clk, .rst, .start, .st, .cmd, .busy);
  sgp_datapath u_dp (.clk, .rst, .cmd, .num_parts, .req_type, .vertex, .neighbor,
    .last_neighbor, .random_part, .table_index, .table_value, .st, .done,
    .placed_vertex, .chosen_part, .had_old_part, .old_part);

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without work");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    !st.clear_done |-> busy) else $error("accepting during clear");
  a_old_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !had_old_part) |-> old_part == 4'd0) else $error("stale old part");
endmodule

// ----- rtl/sgp_ctrl.sv -----
`timescale 1ns / 1ps
module sgp_ctrl import sgp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t st,
  output cmd_t  cmd,
  output logic  busy
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (st.clear_done) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) state_next = ST_NBR_RD;
      end
      ST_NBR_RD: begin
        if (st.is_table) state_next = ST_IDLE;
        else if (st.is_rand) state_next = ST_MEM_RD;
        else if (st.is_nbr) state_next = ST_NBR_UPD;
        else state_next = ST_IDLE;
      end
      ST_NBR_UPD: state_next = st.last ? ST_TBL_RD : ST_IDLE;
      ST_TBL_RD: state_next = ST_TBL_WAIT;
      ST_TBL_WAIT: state_next = ST_SCORE;
      ST_SCORE: state_next = st.scan_done ? ST_MEM_RD : ST_TBL_RD;
      ST_MEM_RD: state_next = ST_MEM_WAIT;
      ST_MEM_WAIT: state_next = ST_PLACE;
      ST_PLACE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: cmd.capture = start;
      ST_NBR_RD: begin
        cmd.nbr_rd = st.is_nbr;
        cmd.tbl_wr = st.is_table;
      end
      ST_NBR_UPD: cmd.nbr_upd = 1'b1;
      ST_TBL_RD: cmd.tbl_rd = 1'b1;
      ST_SCORE: cmd.score = 1'b1;
      ST_MEM_RD: cmd.mem_rd = 1'b1;
      ST_PLACE: cmd.place = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

// ----- rtl/sgp_datapath.sv -----
`timescale 1ns / 1ps
module sgp_datapath import sgp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [4:0]  num_parts,
  input  logic [1:0]  req_type,
  input  logic [15:0] vertex,
  input  logic [15:0] neighbor,
  input  logic        last_neighbor,
  input  logic [3:0]  random_part,
  input  logic [15:0] table_index,
  input  logic [23:0] table_value,
  output stat_t       st,
  output logic        done,
  output logic [15:0] placed_vertex,
  output logic [3:0]  chosen_part,
  output logic        had_old_part,
  output logic [3:0]  old_part
);
  // membership: bit PW valid, low bits partition
  logic [PW:0] mem [MaxVerts];
  logic [23:0] ptab [2**TW];
  logic [CW-1:0] part_size [MaxParts];
  logic [CW-1:0] ncount [MaxParts];

  logic [1:0] r_req;
  logic [15:0] r_vtx, r_nbr, r_ti;
  logic r_last;
  logic [3:0] r_rp;
  logic [23:0] r_tv;
  logic [VW:0] clr_addr;
  logic [PW:0] mem_q;
  logic [23:0] tab_q;
  logic [PW-1:0] scan, best;
  logic signed [26:0] top_score;
  logic [PW-1:0] part_sel;
  logic [PW:0] np;

  always_comb begin
    if (num_parts == 5'd0) np = (PW+1)'(1);
    else if (num_parts > 5'(MaxParts)) np = (PW+1)'(MaxParts);
    else np = num_parts[PW:0];
  end

  assign st.clear_done = clr_addr[VW];
  assign st.is_nbr = (r_req == ReqNbr);
  assign st.is_rand = (r_req == ReqRand);
  assign st.is_table = (r_req == ReqTable);
  assign st.last = r_last;
  assign st.scan_done = ({1'b0, scan} == np - 1'b1);

  logic [VW-1:0] mem_addr;
  assign mem_addr = cmd.nbr_rd ? r_nbr[VW-1:0] : r_vtx[VW-1:0];

  logic [TW-1:0] tab_addr;
  always_comb begin
    if (part_size[scan] > CW'(2**TW - 1)) tab_addr = {TW{1'b1}};
    else tab_addr = part_size[scan][TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step && !clr_addr[VW]) mem[clr_addr[VW-1:0]] <= '0;
    else if (cmd.place) mem[r_vtx[VW-1:0]] <= {1'b1, part_sel};
    if (cmd.nbr_rd || cmd.mem_rd) mem_q <= mem[mem_addr];
    if (cmd.tbl_wr) ptab[r_ti] <= r_tv;
    if (cmd.tbl_rd) tab_q <= ptab[tab_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear_step && !clr_addr[VW]) clr_addr <= clr_addr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_req <= req_type; r_vtx <= vertex; r_nbr <= neighbor;
      r_last <= last_neighbor; r_rp <= random_part; r_ti <= table_index;
      r_tv <= table_value;
    end
  end

  // random partition saturates to the last one in use
  logic [PW-1:0] rp_sat;
  assign rp_sat = ({1'b0, r_rp[PW-1:0]} >= np) ? PW'(np - 1'b1) : r_rp[PW-1:0];
  assign part_sel = st.is_rand ? rp_sat : best;

  logic signed [26:0] score_now;
  assign score_now = $signed({2'b0, ncount[scan], 8'b0}) - $signed({3'b0, tab_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
      for (int i = 0; i < MaxParts; i++) begin
        part_size[i] <= '0;
        ncount[i] <= '0;
      end
      done <= 1'b0;
    end else begin
      done <= cmd.place;
      if (cmd.nbr_upd && mem_q[PW] && ({1'b0, mem_q[PW-1:0]} < np) &&
          ncount[mem_q[PW-1:0]] != CntMax)
        ncount[mem_q[PW-1:0]] <= ncount[mem_q[PW-1:0]] + 1'b1;
      if (cmd.score) begin
        if (scan == '0 || score_now > top_score) begin
          top_score <= score_now;
          best <= scan;
        end
        scan <= st.scan_done ? '0 : scan + 1'b1;
      end
      if (cmd.place) begin
        placed_vertex <= r_vtx;
        chosen_part <= part_sel;
        had_old_part <= mem_q[PW];
        old_part <= mem_q[PW] ? mem_q[PW-1:0] : '0;
        if (!(mem_q[PW] && mem_q[PW-1:0] == part_sel)) begin
          if (part_size[part_sel] != CntMax)
            part_size[part_sel] <= part_size[part_sel] + 1'b1;
          if (mem_q[PW] && part_size[mem_q[PW-1:0]] != '0)
            part_size[mem_q[PW-1:0]] <= part_size[mem_q[PW-1:0]] - 1'b1;
        end
        if (st.is_nbr)
          for (int i = 0; i < MaxParts; i++) ncount[i] <= '0;
      end
    end
  end
endmodule

// ----- bench/tb_streaming_graph_partitioner.sv -----
`timescale 1ns / 1ps
module tb_streaming_graph_partitioner import sgp_pkg::*; ();

  localparam logic [1:0] ReqNop = 2'd3;
  localparam int CycleLimit = 3000000;
  localparam int VertPool = 48;

  typedef struct {
    logic [1:0]  rq;
    logic [15:0] v;
    logic [15:0] nb;
    logic        last;
    logic [3:0]  rp;
    logic [15:0] ti;
    logic [23:0] tv;
  } word_t;

  typedef struct {
    logic [15:0] v;
    logic [3:0]  part;
    logic        had;
    logic [3:0]  old;
  } move_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, had_old_part, pready;
  logic [1:0] req_type = '0;
  logic [15:0] vertex = '0, neighbor = '0, table_index = '0;
  logic last_neighbor = 1'b0;
  logic [3:0] random_part = '0;
  logic [23:0] table_value = '0;
  logic [15:0] placed_vertex;
  logic [3:0] chosen_part, old_part;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;

  streaming_graph_partitioner dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // block state as predicted
  logic        mem_valid [MaxVerts];
  logic [3:0]  mem_part [MaxVerts];
  logic [CW-1:0] size_of [MaxParts];
  logic [CW-1:0] nbr_cnt [MaxParts];
  logic [23:0] penalty [MaxVerts];
  logic        penalty_set [MaxVerts];
  logic [4:0]  num_parts_reg;

  move_t pending_moves[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  function automatic int parts_used();
    int p;
    p = num_parts_reg;
    if (p < 1) p = 1;
    if (p > MaxParts) p = MaxParts;
    return p;
  endfunction

  function automatic move_t move_vertex(logic [15:0] v, logic [3:0] part);
    move_t m;
    m.v = v;
    m.part = part;
    m.had = mem_valid[v];
    m.old = mem_valid[v] ? mem_part[v] : 4'd0;
    mem_valid[v] = 1'b1;
    mem_part[v] = part;
    if (!(m.had && m.old == part)) begin
      if (size_of[part] != CntMax) size_of[part]++;
      if (m.had && size_of[m.old] != 0) size_of[m.old]--;
    end
    return m;
  endfunction

  // returns 1 when the word yields a placement
  function automatic bit predict_word(word_t w, output move_t m);
    int np, best;
    longint sc, best_sc;
    logic [CW-1:0] idx;
    np = parts_used();
    m = '{default: '0};
    case (w.rq)
      ReqTable: begin
        penalty[w.ti] = w.tv;
        penalty_set[w.ti] = 1'b1;
        return 0;
      end
      ReqRand: begin
        m = move_vertex(w.v, (w.rp >= np) ? 4'(np - 1) : w.rp);
        return 1;
      end
      ReqNbr: begin
        if (mem_valid[w.nb] && mem_part[w.nb] < np && nbr_cnt[mem_part[w.nb]] != CntMax)
          nbr_cnt[mem_part[w.nb]]++;
        if (!w.last) return 0;
        best = 0;
        best_sc = 0;
        for (int s = 0; s < np; s++) begin
          idx = (size_of[s] > CW'(65535)) ? CW'(65535) : size_of[s];
          sc = longint'(nbr_cnt[s]) * 256 - longint'(penalty[idx[15:0]]);
          if (s == 0 || sc > best_sc) begin
            best_sc = sc;
            best = s;
          end
        end
        for (int s = 0; s < MaxParts; s++) nbr_cnt[s] = '0;
        m = move_vertex(w.v, 4'(best));
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    move_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
    if (!rst && done) begin
      if (pending_moves.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected placement of vertex %0d", placed_vertex);
      end else begin
        e = pending_moves.pop_front();
        if (placed_vertex !== e.v || chosen_part !== e.part || had_old_part !== e.had ||
            old_part !== e.old) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp v=%0d p=%0d had=%0d old=%0d got v=%0d p=%0d had=%0d old=%0d",
                     e.v, e.part, e.had, e.old, placed_vertex, chosen_part, had_old_part,
                     old_part);
        end
      end
    end
  end

  task automatic send_word(word_t w);
    move_t m;
    int gap;
    req_type <= w.rq;
    vertex <= w.v;
    neighbor <= w.nb;
    last_neighbor <= w.last;
    random_part <= w.rp;
    table_index <= w.ti;
    table_value <= w.tv;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (predict_word(w, m)) pending_moves.push_back(m);
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic word_t noise_word();
    word_t w;
    w.rq = 2'($urandom);
    w.v = 16'($urandom);
    w.nb = 16'($urandom);
    w.last = 1'($urandom);
    w.rp = 4'($urandom);
    w.ti = 16'($urandom);
    w.tv = 24'($urandom);
    return w;
  endfunction

  task automatic write_table(logic [15:0] idx, logic [23:0] val);
    word_t w;
    w = noise_word();
    w.rq = ReqTable;
    w.ti = idx;
    w.tv = val;
    send_word(w);
  endtask

  function automatic logic [23:0] pick_penalty();
    if ($urandom_range(9) == 0) return 24'($urandom);
    return 24'($urandom_range(0, 1024));
  endfunction

  // make sure every size the argmax will look up has a table entry
  task automatic fill_penalties();
    int np;
    logic [CW-1:0] sz;
    np = parts_used();
    for (int s = 0; s < np; s++) begin
      sz = size_of[s];
      if (sz > CW'(65535)) sz = CW'(65535);
      if (!penalty_set[sz[15:0]]) write_table(sz[15:0], pick_penalty());
    end
  endtask

  function automatic logic [15:0] pick_vertex();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, VertPool - 1));
  endfunction

  task automatic send_nbr(logic [15:0] v, logic [15:0] nb, logic last);
    word_t w;
    w = noise_word();
    w.rq = ReqNbr;
    w.v = v;
    w.nb = nb;
    w.last = last;
    if (last) fill_penalties();
    send_word(w);
  endtask

  task automatic send_lone(logic [15:0] v, logic [3:0] rp);
    word_t w;
    w = noise_word();
    w.rq = ReqRand;
    w.v = v;
    w.rp = rp;
    send_word(w);
  endtask

  // one vertex with random neighbors; returns the number of words sent
  task automatic send_vertex(output int sent);
    logic [15:0] v;
    int k;
    v = pick_vertex();
    k = $urandom_range(0, 6);
    sent = 0;
    if (k == 0) begin
      send_lone(v, 4'($urandom));
      sent = 1;
      return;
    end
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(19) == 0) begin
        send_lone(pick_vertex(), 4'($urandom));
        sent++;
      end
      send_nbr(v, pick_vertex(), i == k - 1);
      sent++;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_num_parts(logic [4:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= AddrNumParts;
    pwdata <= {27'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    num_parts_reg = val;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_directed();
    word_t w;
    idle_pct = 0;
    write_table(16'hFFFF, 24'hFFFFFF);
    write_table(16'd0, 24'd0);
    send_lone(16'd0, 4'd15);           // last partition, already in range
    send_lone(16'hFFFF, 4'd0);
    send_lone(16'd0, 4'd15);           // same partition again
    send_nbr(16'd1, 16'd0, 1'b0);
    send_nbr(16'd1, 16'hFFFF, 1'b0);
    send_lone(16'd2, 4'd3);            // interleaved lone vertex
    send_nbr(16'd1, 16'd2, 1'b0);
    send_nbr(16'd1, 16'd77, 1'b1);     // unknown neighbor
    send_nbr(16'd1, 16'd0, 1'b1);      // move an already placed vertex
    w = noise_word();
    w.rq = ReqNop;
    send_word(w);
    drain();
    write_num_parts(5'd3);
    send_nbr(16'd5, 16'd0, 1'b1);      // neighbor in partition beyond range
    send_lone(16'd6, 4'd15);
    send_nbr(16'd7, 16'd6, 1'b1);
    drain();
  endtask

  task automatic test_phase(logic [4:0] np, int pct, int words);
    int n, sent;
    write_num_parts(np);
    idle_pct = pct;
    n = 0;
    while (n < words) begin
      case ($urandom_range(9))
        0: begin
          write_table(16'($urandom), 24'($urandom));
          n++;
        end
        1: begin
          if ($urandom_range(3) == 0) begin
            // a random word may close a vertex, so cover its table lookups
            fill_penalties();
            send_word(noise_word());
          end
          send_vertex(sent);
          n += sent;
        end
        default: begin
          send_vertex(sent);
          n += sent;
        end
      endcase
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < MaxVerts; i++) begin
      mem_valid[i] = 1'b0;
      mem_part[i] = '0;
      penalty[i] = '0;
      penalty_set[i] = 1'b0;
    end
    for (int i = 0; i < MaxParts; i++) begin
      size_of[i] = '0;
      nbr_cnt[i] = '0;
    end
    num_parts_reg = 5'd16;
    test_directed();
    test_phase(5'd16, 0, 130);
    test_phase(5'd1, 86, 90);
    test_phase(5'd0, 0, 60);
    test_phase(5'd31, 86, 130);
    test_phase(5'd5, 9, 130);
    test_phase(5'd2, 0, 120);
    test_phase(5'd16, 86, 110);
    test_phase(5'd9, 9, 110);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
